### rtl/wm_pkg.sv
// Package with the shared widths of the window median block.
package wm_pkg;

  // Payload widths of the input and result words.
  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int COUNT_W  = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [MEDIAN_W-1:0] median_t;
  typedef logic [COUNT_W-1:0]         count_t;

endpackage

### rtl/window_median.sv
// Top level of the window median block: sorted sample store and median output.
//
// Collects up to WINDOW signed Q24.8 samples per block in a RAM kept in
// ascending order and, on the word marked last, returns the median in Q24.9
// together with the number of samples kept and a flag for dropped samples.
// A sample is placed by insertion: the entries above its place are moved up
// one at a time through the single read and write port of the store. A
// sample that arrives into an empty store is written straight to the bottom
// entry, and one that arrives into a full store is dropped. The word marked
// last then reads the two middle entries, adds them and loads the output
// register. The input side is taken again while a result waits in the output
// register; only a following last word waits for that register to empty. No
// clearing pass is needed after reset: only entries below the fill count are
// ever used.
module window_median #(
  parameter int WINDOW = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              in_sample,
  input  logic                     in_last,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [32:0]       out_median,
  output logic [4:0]               out_sample_count,
  output logic                     out_overflowed
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PUT,
    ST_MRD_A,
    ST_MRD_B,
    ST_MSUM,
    ST_MOUT
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     fill_count_r, fill_count_nxt;
  logic              drop_flag_r, drop_flag_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  wm_pkg::sample_t   v_r, v_nxt;
  logic              last_r, last_nxt;
  wm_pkg::sample_t   mid_a_r, mid_a_nxt;
  wm_pkg::median_t   sum_r, sum_nxt;
  logic              out_valid_r, out_valid_nxt;
  wm_pkg::median_t   out_median_r, out_median_nxt;
  wm_pkg::count_t    out_count_r, out_count_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;

  logic              in_fire;
  logic              store_full;
  logic              out_free;

  // Sorted sample store.
  wm_ram #(
    .WIDTH(wm_pkg::SAMPLE_W),
    .DEPTH(WINDOW)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign store_full = (fill_count_r == CW'(WINDOW));
  assign out_free   = !out_valid_r || out_ready;

  // Sequencer: insertion into the store, then the median read-out.
  always_comb begin
    state_nxt      = state_r;
    fill_count_nxt = fill_count_r;
    drop_flag_nxt  = drop_flag_r;
    pos_nxt        = pos_r;
    v_nxt          = v_r;
    last_nxt       = last_r;
    mid_a_nxt      = mid_a_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;
    out_count_nxt  = out_count_r;
    out_ovf_nxt    = out_ovf_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = v_r;
    ram_raddr      = pos_r;

    // The output word leaves when the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          v_nxt    = in_sample;
          last_nxt = in_last;
          if (store_full) begin
            // No room: the sample is dropped and the block is flagged.
            drop_flag_nxt = 1'b1;
            state_nxt     = in_last ? ST_MRD_A : ST_IDLE;
          end else if (fill_count_r == '0) begin
            // Empty store: the sample goes straight to the bottom entry.
            ram_we         = 1'b1;
            ram_waddr      = '0;
            ram_wdata      = in_sample;
            fill_count_nxt = fill_count_r + 1'b1;
            state_nxt      = in_last ? ST_MRD_A : ST_IDLE;
          end else begin
            // Start at the free slot and look at the entry below it.
            pos_nxt   = AW'(fill_count_r);
            ram_raddr = AW'(fill_count_r - 1'b1);
            state_nxt = ST_INS;
          end
        end
      end

      ST_INS: begin
        if ($signed(ram_rdata) > v_r) begin
          // Move the larger entry up one place and read the next one down.
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - 1'b1;
          ram_raddr = AW'(pos_r - AW'(2));
          if (pos_r == AW'(1)) begin
            state_nxt = ST_PUT;
          end
        end else begin
          ram_we         = 1'b1;
          ram_waddr      = pos_r;
          ram_wdata      = v_r;
          fill_count_nxt = fill_count_r + 1'b1;
          state_nxt      = last_r ? ST_MRD_A : ST_IDLE;
        end
      end

      ST_PUT: begin
        // Sample is the smallest so far: it takes the bottom entry.
        ram_we         = 1'b1;
        ram_waddr      = pos_r;
        ram_wdata      = v_r;
        fill_count_nxt = fill_count_r + 1'b1;
        state_nxt      = last_r ? ST_MRD_A : ST_IDLE;
      end

      ST_MRD_A: begin
        // Lower middle entry; equals the upper one for an odd count.
        ram_raddr = AW'((fill_count_r - 1'b1) >> 1);
        state_nxt = ST_MRD_B;
      end

      ST_MRD_B: begin
        ram_raddr = AW'(fill_count_r >> 1);
        mid_a_nxt = ram_rdata;
        state_nxt = ST_MSUM;
      end

      ST_MSUM: begin
        // Sum of the two middle Q24.8 values is the mean in Q24.9.
        sum_nxt   = {mid_a_r[31], mid_a_r} + {ram_rdata[31], ram_rdata};
        state_nxt = ST_MOUT;
      end

      ST_MOUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_median_nxt = sum_r;
          out_count_nxt  = wm_pkg::COUNT_W'(fill_count_r);
          out_ovf_nxt    = drop_flag_r;
          fill_count_nxt = '0;
          drop_flag_nxt  = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, counters and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_count_r <= '0;
      drop_flag_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      drop_flag_r  <= drop_flag_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    v_r          <= v_nxt;
    last_r       <= last_nxt;
    mid_a_r      <= mid_a_nxt;
    sum_r        <= sum_nxt;
    out_median_r <= out_median_nxt;
    out_count_r  <= out_count_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_median       = out_median_r;
  assign out_sample_count = out_count_r;
  assign out_overflowed   = out_ovf_r;

endmodule

### rtl/wm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module wm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/wm_checker.sv
// Port-level checker for the window median block, with its bind statement.
module wm_checker #(
  parameter int WINDOW = 16
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [32:0] out_median,
  input logic [4:0]        out_sample_count,
  input logic              out_overflowed
);

  // A result word that is not taken holds with its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_median) &&
      $stable(out_sample_count) && $stable(out_overflowed))
    else $error("result word changed before it was taken");

  // An odd count gives twice the middle sample, so no half fraction bit.
  a_odd_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sample_count[0] |-> !out_median[0])
    else $error("odd count median has a half fraction bit");

  // A dropped sample means the store was full.
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflowed |-> out_sample_count == 5'(WINDOW))
    else $error("overflow flagged with a store that was not full");

  // A new result never appears in the cycle after a sample was taken.
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result word appeared too early");

endmodule

bind window_median wm_checker #(
  .WINDOW(WINDOW)
) u_wm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_median       (out_median),
  .out_sample_count (out_sample_count),
  .out_overflowed   (out_overflowed)
);
